### rtl/sm4_pkg.sv
// ----------------------------------------------------------------------------
// SM4 cipher package
// Transaction types, request codes, round constants and the SM4 byte S-box.
// ----------------------------------------------------------------------------
`default_nettype none

package sm4_pkg;

	localparam int ROUNDS = 32;
	localparam int RK_AW  = $clog2(ROUNDS);

	localparam logic [RK_AW-1:0] FIRST_RND = '0;
	localparam logic [RK_AW-1:0] LAST_RND  = RK_AW'(ROUNDS - 1);

	// Request codes.
	localparam logic [1:0] REQ_KEY = 2'd0;
	localparam logic [1:0] REQ_ENC = 2'd1;
	localparam logic [1:0] REQ_DEC = 2'd2;

	// Rotation amounts of the linear transform L.
	localparam int ROT_A = 2;
	localparam int ROT_B = 10;
	localparam int ROT_C = 18;
	localparam int ROT_D = 24;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [4:0]  key_index;
		logic [31:0] key_word;
		logic [63:0] block_high;
		logic [63:0] block_low;
	} sm4_req_t;

	typedef struct packed {
		logic [63:0] result_high;
		logic [63:0] result_low;
	} sm4_rsp_t;

	localparam logic [7:0] SBOX [0:255] = '{
		8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
		8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
		8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
		8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
		8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
		8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
		8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
		8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
		8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
		8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
		8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
		8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
		8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
		8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
		8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
		8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
		8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
		8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
		8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
		8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
		8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
		8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
		8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
		8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
		8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
		8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
		8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
		8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
		8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
		8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
		8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
		8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
	};

endpackage

`default_nettype wire

### rtl/sm4_block_cipher.sv
// ----------------------------------------------------------------------------
// SM4 block cipher core
// 128-bit SM4 encrypt/decrypt engine with a 32-entry round key RAM.
// ----------------------------------------------------------------------------
// A key transaction (req_type REQ_KEY) writes one 32-bit round key into slot
// key_index of the key RAM and returns nothing; slots never written read as
// zero. An encrypt or decrypt transaction presents its 128-bit result after
// its final round: the first round key is read from the RAM at the edge that
// accepts it, then 32 rounds follow at one round per cycle through the single
// round unit, each round using the key prefetched from the RAM as the engine
// started or the previous round stepped. Decryption walks the keys from slot
// 31 down to slot 0. A new request is taken the cycle after the final round.
// The finished block sits in an output register, so the next request can be
// accepted while the result still waits; only if a second block reaches its
// final round with the previous result still untaken does the engine wait.
// Request code 3 is accepted and dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module sm4_block_cipher (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire sm4_pkg::sm4_req_t req,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output sm4_pkg::sm4_rsp_t      rsp
);

	import sm4_pkg::*;

	// Engine control.
	logic             busy_q;
	logic             dec_q;
	logic [RK_AW-1:0] rnd_q;
	logic [RK_AW-1:0] rnd_nxt;
	logic             rsp_valid_q;
	sm4_rsp_t         rsp_q;

	// Working words of the block.
	logic [31:0] w0_q, w1_q, w2_q, w3_q;

	// Key RAM and its per-slot written flags (unwritten slots read as zero).
	logic [ROUNDS-1:0] key_vld_q;
	logic              kvld_s1;
	logic              rd_en;
	logic [RK_AW-1:0]  rd_addr;
	logic [31:0]       rd_data;
	logic [31:0]       rk;

	logic        accept;
	logic        start;
	logic        key_wr;
	logic        out_free;
	logic        step;
	logic        last;
	logic [31:0] f;
	logic [31:0] nw;

	// The engine only takes a request when no block is in flight.
	assign req_stall = busy_q;
	assign accept    = req_valid && !busy_q;
	assign key_wr    = accept && (req.req_type == REQ_KEY);
	assign start     = accept && ((req.req_type == REQ_ENC) || (req.req_type == REQ_DEC));

	// The last round commits into the output register, which must be free
	// or handing its current result over in this cycle.
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign last     = (rnd_q == LAST_RND);
	assign step     = busy_q && (!last || out_free);
	assign rnd_nxt  = rnd_q + RK_AW'(1);

	// Prefetch the key for the following round; decryption mirrors the index.
	always_comb begin
		rd_en = start || (step && !last);
		if (start) begin
			rd_addr = (req.req_type == REQ_DEC) ? LAST_RND : FIRST_RND;
		end else begin
			rd_addr = rnd_nxt ^ {RK_AW{dec_q}};
		end
	end

	sm4_ram #(
		.WIDTH (32),
		.DEPTH (ROUNDS)
	) u_key_ram (
		.clk     (clk),
		.wr_en   (key_wr),
		.wr_addr (req.key_index),
		.wr_data (req.key_word),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign rk = kvld_s1 ? rd_data : '0;

	sm4_round u_round (
		.w1 (w1_q),
		.w2 (w2_q),
		.w3 (w3_q),
		.rk (rk),
		.f  (f)
	);

	assign nw = w0_q ^ f;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			dec_q       <= 1'b0;
			rnd_q       <= '0;
			rsp_valid_q <= 1'b0;
			key_vld_q   <= '0;
			kvld_s1     <= 1'b0;
		end else begin
			if (key_wr) begin
				key_vld_q[req.key_index] <= 1'b1;
			end
			if (rd_en) begin
				kvld_s1 <= key_vld_q[rd_addr];
			end
			if (start) begin
				busy_q <= 1'b1;
				dec_q  <= (req.req_type == REQ_DEC);
				rnd_q  <= FIRST_RND;
			end else if (step) begin
				rnd_q <= rnd_nxt;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
			if (step && last) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Data path registers carry no reset.
	always_ff @(posedge clk) begin
		if (start) begin
			w0_q <= req.block_high[63:32];
			w1_q <= req.block_high[31:0];
			w2_q <= req.block_low[63:32];
			w3_q <= req.block_low[31:0];
		end else if (step) begin
			w0_q <= w1_q;
			w1_q <= w2_q;
			w2_q <= w3_q;
			w3_q <= nw;
		end
		// Output is the final four words in reverse order.
		if (step && last) begin
			rsp_q.result_high <= {nw, w3_q};
			rsp_q.result_low  <= {w2_q, w1_q};
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	// A cipher request starts the engine at the first round.
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (busy_q && (rnd_q == FIRST_RND)))
		else $error("engine did not start at the first round");

	// Rounds advance one at a time while the engine runs.
	a_round_step: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !last) |=> (busy_q && (rnd_q == RK_AW'($past(rnd_q) + 1'b1))))
		else $error("round counter skipped or stalled");

	// A new result appears only out of the final round.
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(busy_q && last))
		else $error("result raised outside the final round");

	// The final round never overwrites a result still waiting downstream.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_stall) |=> (rsp_valid_q && $stable(rsp_q)))
		else $error("waiting result was overwritten");

	// A key write marks its slot as written.
	a_key_mark: assert property (@(posedge clk) disable iff (!arst_n)
		key_wr |=> key_vld_q[$past(req.key_index)])
		else $error("key slot not marked after write");
`endif

endmodule

`default_nettype wire

### rtl/sm4_ram.sv
// ----------------------------------------------------------------------------
// SM4 generic RAM
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sm4_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

### rtl/sm4_round.sv
// ----------------------------------------------------------------------------
// SM4 round function
// Mixes three words with the round key, substitutes bytes, applies L.
// ----------------------------------------------------------------------------
`default_nettype none

module sm4_round (
	input  wire logic [31:0] w1,
	input  wire logic [31:0] w2,
	input  wire logic [31:0] w3,
	input  wire logic [31:0] rk,
	output logic      [31:0] f
);

	import sm4_pkg::*;

	logic [31:0] mix;
	logic [31:0] sub;

	always_comb begin
		mix = w1 ^ w2 ^ w3 ^ rk;
		for (int i = 0; i < 4; i++) begin
			sub[8*i +: 8] = SBOX[mix[8*i +: 8]];
		end
		f = sub
		  ^ ((sub << ROT_A) | (sub >> (32 - ROT_A)))
		  ^ ((sub << ROT_B) | (sub >> (32 - ROT_B)))
		  ^ ((sub << ROT_C) | (sub >> (32 - ROT_C)))
		  ^ ((sub << ROT_D) | (sub >> (32 - ROT_D)));
	end

endmodule

`default_nettype wire
